/* rtl/ptw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes and control types of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int TABLE_PAGES_DEF   = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;

   localparam int OP_W       = 2;
   localparam int VA_W       = 48;
   localparam int PA_W       = 52;
   localparam int FLAGS_W    = 12;
   localparam int ENTRY_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int ROOT_W     = 6;
   localparam int FFP_W      = 7;
   localparam int BASE_W     = 52;
   localparam int OFF_W      = 12;
   localparam int PFN_W      = ENTRY_W - OFF_W;
   localparam int BASE_PFN_W = BASE_W - OFF_W;
   localparam int LEVEL_W    = 2;

   localparam int REQ_DATA_W = ((VA_W + PA_W + FLAGS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ENTRY_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_TABLE_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROOT_PAGE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_FREE = 2'd2;

   localparam logic [FFP_W-1:0] FIRST_FREE_RESET = 7'd1;

   localparam logic [OP_W-1:0] OP_MAP       = 2'd0;
   localparam logic [OP_W-1:0] OP_UNMAP     = 2'd1;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

   localparam logic [OFF_W-1:0]   DIR_FLAGS  = 12'h003;
   localparam logic [LEVEL_W-1:0] LEAF_LEVEL = 2'd3;

   // datapath actions, one per microcode step
   localparam int ACT_W = 5;
   localparam logic [ACT_W-1:0] ACT_NONE     = 5'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 5'd1;
   localparam logic [ACT_W-1:0] ACT_LOAD     = 5'd2;
   localparam logic [ACT_W-1:0] ACT_START    = 5'd3;
   localparam logic [ACT_W-1:0] ACT_READ     = 5'd4;
   localparam logic [ACT_W-1:0] ACT_TAKE     = 5'd5;
   localparam logic [ACT_W-1:0] ACT_OFFSET   = 5'd6;
   localparam logic [ACT_W-1:0] ACT_DESCEND  = 5'd7;
   localparam logic [ACT_W-1:0] ACT_ALLOC    = 5'd8;
   localparam logic [ACT_W-1:0] ACT_ZERO     = 5'd9;
   localparam logic [ACT_W-1:0] ACT_LINK     = 5'd10;
   localparam logic [ACT_W-1:0] ACT_WR_LEAF  = 5'd11;
   localparam logic [ACT_W-1:0] ACT_CLR_LEAF = 5'd12;
   localparam logic [ACT_W-1:0] ACT_RESULT   = 5'd13;
   localparam logic [ACT_W-1:0] ACT_ST_ZERO  = 5'd14;
   localparam logic [ACT_W-1:0] ACT_ST_FULL  = 5'd15;
   localparam logic [ACT_W-1:0] ACT_ST_OUT   = 5'd16;
   localparam logic [ACT_W-1:0] ACT_RESP     = 5'd17;

   typedef struct packed {
      logic op_bad;
      logic root_bad;
      logic look_zero;
      logic map_absent;
      logic off_bad;
      logic not_leaf;
      logic is_map;
      logic is_unmap;
      logic full;
      logic zero_more;
      logic clr_more;
   } dp_flags_type;

endpackage

/* rtl/ptw_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_seq
// Microcode sequencer: step counter, control ROM and jump condition select.
// ----------------------------------------------------------------------------
module ptw_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  ptw_pkg::dp_flags_type       flags,
   input  logic                        req_valid,
   input  logic                        out_busy,
   output logic [ptw_pkg::ACT_W-1:0]   act
);
   import ptw_pkg::*;

   localparam int UPC_W  = 5;
   localparam int COND_W = 4;

   localparam logic [COND_W-1:0] C_ALWAYS     = 4'd0;
   localparam logic [COND_W-1:0] C_NEVER      = 4'd1;
   localparam logic [COND_W-1:0] C_NO_REQ     = 4'd2;
   localparam logic [COND_W-1:0] C_OP_BAD     = 4'd3;
   localparam logic [COND_W-1:0] C_ROOT_BAD   = 4'd4;
   localparam logic [COND_W-1:0] C_LOOK_ZERO  = 4'd5;
   localparam logic [COND_W-1:0] C_MAP_ABSENT = 4'd6;
   localparam logic [COND_W-1:0] C_OFF_BAD    = 4'd7;
   localparam logic [COND_W-1:0] C_NOT_LEAF   = 4'd8;
   localparam logic [COND_W-1:0] C_IS_MAP     = 4'd9;
   localparam logic [COND_W-1:0] C_IS_UNMAP   = 4'd10;
   localparam logic [COND_W-1:0] C_FULL       = 4'd11;
   localparam logic [COND_W-1:0] C_ZERO_MORE  = 4'd12;
   localparam logic [COND_W-1:0] C_CLR_MORE   = 4'd13;
   localparam logic [COND_W-1:0] C_OUT_BUSY   = 4'd14;
   localparam logic [COND_W-1:0] C_OUT_FREE   = 4'd15;

   localparam logic [UPC_W-1:0] S_CLEAR    = 5'd0;
   localparam logic [UPC_W-1:0] S_IDLE     = 5'd1;
   localparam logic [UPC_W-1:0] S_OPCHK    = 5'd2;
   localparam logic [UPC_W-1:0] S_ROOTCHK  = 5'd3;
   localparam logic [UPC_W-1:0] S_READ     = 5'd4;
   localparam logic [UPC_W-1:0] S_TAKE     = 5'd5;
   localparam logic [UPC_W-1:0] S_CHK_ZERO = 5'd6;
   localparam logic [UPC_W-1:0] S_CHK_PRES = 5'd7;
   localparam logic [UPC_W-1:0] S_DESC     = 5'd8;
   localparam logic [UPC_W-1:0] S_LVLCHK   = 5'd9;
   localparam logic [UPC_W-1:0] S_LEAF     = 5'd10;
   localparam logic [UPC_W-1:0] S_LEAF2    = 5'd11;
   localparam logic [UPC_W-1:0] S_XLAT     = 5'd12;
   localparam logic [UPC_W-1:0] S_MAP_WR   = 5'd13;
   localparam logic [UPC_W-1:0] S_UNMAP_WR = 5'd14;
   localparam logic [UPC_W-1:0] S_ALLOC    = 5'd15;
   localparam logic [UPC_W-1:0] S_ZERO     = 5'd16;
   localparam logic [UPC_W-1:0] S_LINK     = 5'd17;
   localparam logic [UPC_W-1:0] S_ERR_ZERO = 5'd18;
   localparam logic [UPC_W-1:0] S_ERR_FULL = 5'd19;
   localparam logic [UPC_W-1:0] S_ERR_OUT  = 5'd20;
   localparam logic [UPC_W-1:0] S_RESP     = 5'd21;
   localparam logic [UPC_W-1:0] S_HOLD     = 5'd22;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type w;
      unique case (addr)
         S_CLEAR:    w = '{ACT_CLEAR,    C_CLR_MORE,   S_CLEAR};
         S_IDLE:     w = '{ACT_LOAD,     C_NO_REQ,     S_IDLE};
         S_OPCHK:    w = '{ACT_START,    C_OP_BAD,     S_RESP};
         S_ROOTCHK:  w = '{ACT_NONE,     C_ROOT_BAD,   S_ERR_OUT};
         S_READ:     w = '{ACT_READ,     C_NEVER,      S_READ};
         S_TAKE:     w = '{ACT_TAKE,     C_NEVER,      S_TAKE};
         S_CHK_ZERO: w = '{ACT_OFFSET,   C_LOOK_ZERO,  S_ERR_ZERO};
         S_CHK_PRES: w = '{ACT_NONE,     C_MAP_ABSENT, S_ALLOC};
         S_DESC:     w = '{ACT_DESCEND,  C_OFF_BAD,    S_ERR_OUT};
         S_LVLCHK:   w = '{ACT_NONE,     C_NOT_LEAF,   S_READ};
         S_LEAF:     w = '{ACT_READ,     C_IS_MAP,     S_MAP_WR};
         S_LEAF2:    w = '{ACT_NONE,     C_IS_UNMAP,   S_UNMAP_WR};
         S_XLAT:     w = '{ACT_RESULT,   C_ALWAYS,     S_RESP};
         S_MAP_WR:   w = '{ACT_WR_LEAF,  C_ALWAYS,     S_RESP};
         S_UNMAP_WR: w = '{ACT_CLR_LEAF, C_ALWAYS,     S_RESP};
         S_ALLOC:    w = '{ACT_ALLOC,    C_FULL,       S_ERR_FULL};
         S_ZERO:     w = '{ACT_ZERO,     C_ZERO_MORE,  S_ZERO};
         S_LINK:     w = '{ACT_LINK,     C_ALWAYS,     S_CHK_ZERO};
         S_ERR_ZERO: w = '{ACT_ST_ZERO,  C_ALWAYS,     S_RESP};
         S_ERR_FULL: w = '{ACT_ST_FULL,  C_ALWAYS,     S_RESP};
         S_ERR_OUT:  w = '{ACT_ST_OUT,   C_ALWAYS,     S_RESP};
         S_RESP:     w = '{ACT_RESP,     C_OUT_FREE,   S_IDLE};
         S_HOLD:     w = '{ACT_NONE,     C_ALWAYS,     S_RESP};
         default:    w = '{ACT_NONE,     C_ALWAYS,     S_IDLE};
      endcase
      return w;
   endfunction

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   ucode_type        word;
   logic             take;

   assign word = ucode_rom(upc_ff);
   assign act  = word.act;

   always_comb begin
      unique case (word.cond)
         C_ALWAYS:     take = 1'b1;
         C_NEVER:      take = 1'b0;
         C_NO_REQ:     take = !req_valid;
         C_OP_BAD:     take = flags.op_bad;
         C_ROOT_BAD:   take = flags.root_bad;
         C_LOOK_ZERO:  take = flags.look_zero;
         C_MAP_ABSENT: take = flags.map_absent;
         C_OFF_BAD:    take = flags.off_bad;
         C_NOT_LEAF:   take = flags.not_leaf;
         C_IS_MAP:     take = flags.is_map;
         C_IS_UNMAP:   take = flags.is_unmap;
         C_FULL:       take = flags.full;
         C_ZERO_MORE:  take = flags.zero_more;
         C_CLR_MORE:   take = flags.clr_more;
         C_OUT_BUSY:   take = out_busy;
         C_OUT_FREE:   take = !out_busy;
         default:      take = 1'b0;
      endcase
      upc_in = take ? word.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* rtl/ptw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_dp
// Walk datapath: table store, walk registers, page allocator, status.
// ----------------------------------------------------------------------------
module ptw_dp #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ptw_pkg::ACT_W-1:0]       act,
   input  logic [ptw_pkg::OP_W-1:0]        op,
   input  logic [ptw_pkg::VA_W-1:0]        virt_addr,
   input  logic [ptw_pkg::PA_W-1:0]        phys_addr,
   input  logic [ptw_pkg::FLAGS_W-1:0]     flags,
   input  logic [ptw_pkg::BASE_W-1:0]      table_base,
   input  logic [ptw_pkg::ROOT_W-1:0]      root_page,
   input  logic [ptw_pkg::FFP_W-1:0]       first_free_page,
   output ptw_pkg::dp_flags_type           dp_flags,
   output logic [ptw_pkg::ENTRY_W-1:0]     result,
   output logic [ptw_pkg::STATUS_W-1:0]    status
);
   import ptw_pkg::*;

   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int USED_W = $clog2(TABLE_PAGES + 1);
   localparam int NP_W   = ((USED_W > FFP_W) ? USED_W : FFP_W) + 1;

   logic [ENTRY_W-1:0] store_mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [PAGE_W-1:0]   page_ff,   page_in;
   logic [LEVEL_W-1:0]  level_ff,  level_in;
   logic [ENTRY_W-1:0]  entry_ff,  entry_in;
   logic [PFN_W:0]      diff_ff,   diff_in;
   logic [ADDR_W-1:0]   sweep_ff,  sweep_in;
   logic [USED_W-1:0]   used_ff,   used_in;
   logic [PAGE_W-1:0]   np_ff,     np_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ENTRY_W-1:0]  result_ff, result_in;

   logic [IDX_W-1:0]        idx;
   logic [ADDR_W-1:0]       cur_addr;
   logic [NP_W-1:0]         np_sum;
   logic [BASE_PFN_W-1:0]   base_pfn;
   logic [PFN_W:0]          diff;
   logic [BASE_PFN_W:0]     link_pfn;
   logic [ENTRY_W-1:0]      link_entry;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]      wr_data;

   always_comb begin
      unique case (level_ff)
         2'd0:    idx = virt_addr[47:39];
         2'd1:    idx = virt_addr[38:30];
         2'd2:    idx = virt_addr[29:21];
         default: idx = virt_addr[20:12];
      endcase
   end

   assign cur_addr   = {page_ff, idx};
   assign np_sum     = NP_W'(first_free_page) + NP_W'(used_ff);
   assign base_pfn   = table_base[BASE_W-1:OFF_W];
   assign diff       = {1'b0, entry_ff[ENTRY_W-1:OFF_W]}
                       - {{(PFN_W + 1 - BASE_PFN_W){1'b0}}, base_pfn};
   assign link_pfn   = {1'b0, base_pfn} + (BASE_PFN_W + 1)'(np_ff);
   assign link_entry = {{(PFN_W - BASE_PFN_W - 1){1'b0}}, link_pfn, DIR_FLAGS};

   // store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = '0;
      unique case (act)
         ACT_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
         end
         ACT_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = {np_ff, sweep_ff[IDX_W-1:0]};
         end
         ACT_LINK: begin
            wr_en   = 1'b1;
            wr_data = link_entry;
         end
         ACT_WR_LEAF: begin
            wr_en   = 1'b1;
            wr_data = {{(ENTRY_W - PA_W){1'b0}}, phys_addr}
                      | {{(ENTRY_W - FLAGS_W){1'b0}}, flags};
         end
         ACT_CLR_LEAF: begin
            wr_en   = 1'b1;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (act == ACT_READ) begin
         rd_data_ff <= store_mem[cur_addr];
      end
   end

   always_comb begin
      page_in   = page_ff;
      level_in  = level_ff;
      entry_in  = entry_ff;
      diff_in   = diff_ff;
      sweep_in  = sweep_ff;
      used_in   = used_ff;
      np_in     = np_ff;
      status_in = status_ff;
      result_in = result_ff;
      unique case (act)
         ACT_START: begin
            page_in   = PAGE_W'(root_page);
            level_in  = '0;
            status_in = ST_OK;
            result_in = '0;
         end
         ACT_TAKE:    entry_in = rd_data_ff;
         ACT_OFFSET:  diff_in  = diff;
         ACT_DESCEND: begin
            page_in  = diff_ff[PAGE_W-1:0];
            level_in = level_ff + 1'b1;
         end
         ACT_ALLOC: begin
            sweep_in = '0;
            np_in    = np_sum[PAGE_W-1:0];
         end
         ACT_ZERO,
         ACT_CLEAR:   sweep_in = sweep_ff + 1'b1;
         ACT_LINK: begin
            entry_in = link_entry;
            used_in  = used_ff + 1'b1;
         end
         ACT_RESULT:  result_in = {rd_data_ff[ENTRY_W-1:OFF_W], {OFF_W{1'b0}}};
         ACT_ST_ZERO: status_in = ST_ZERO;
         ACT_ST_FULL: status_in = ST_FULL;
         ACT_ST_OUT:  status_in = ST_OUTSIDE;
         default: begin
            page_in = page_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         used_ff  <= '0;
      end else begin
         sweep_ff <= sweep_in;
         used_ff  <= used_in;
      end
      page_ff   <= page_in;
      level_ff  <= level_in;
      entry_ff  <= entry_in;
      diff_ff   <= diff_in;
      np_ff     <= np_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign dp_flags.op_bad     = op > OP_TRANSLATE;
   assign dp_flags.root_bad   = {{(32 - ROOT_W){1'b0}}, root_page} >= 32'(TABLE_PAGES);
   assign dp_flags.look_zero  = (op != OP_MAP) && (entry_ff[ENTRY_W-1:OFF_W] == '0);
   assign dp_flags.map_absent = (op == OP_MAP) && !entry_ff[0];
   assign dp_flags.off_bad    = diff_ff[PFN_W] || (diff_ff[PFN_W-1:0] >= PFN_W'(TABLE_PAGES));
   assign dp_flags.not_leaf   = level_ff != LEAF_LEVEL;
   assign dp_flags.is_map     = op == OP_MAP;
   assign dp_flags.is_unmap   = op == OP_UNMAP;
   assign dp_flags.full       = np_sum >= NP_W'(TABLE_PAGES);
   assign dp_flags.zero_more  = sweep_ff[IDX_W-1:0] != IDX_W'(ENTRIES_PER_TABLE - 1);
   assign dp_flags.clr_more   = sweep_ff != ADDR_W'(DEPTH - 1);

   assign result = result_ff;
   assign status = status_ff;

endmodule

/* rtl/four_level_page_table_walker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Map / unmap / translate on a four-level page table held in an on-chip store.
//
// req channel: one word per request (op in tuser, addresses and flags in
// tdata). rsp channel: one word per request, phys_out in tdata, status in
// tuser. csr channel: register writes, always ready; write only while idle.
// A request is taken only when the walker is idle; it runs on a microcoded
// sequencer against a single-port store (one read or one write per cycle).
// When no table is allocated, each upper level of a walk runs six microcode
// steps: read, take, zero check, presence check, descend and level check. The
// next word is taken in the cycle after the result is loaded, and no new
// request is taken while a walk is in flight. Each new table a map allocates
// is zeroed by a sweep before it is linked. Errors end a walk early.
// After reset the store is cleared one entry a cycle with req_tready low;
// csr writes are taken meanwhile.
// A result waits in the output register while rsp_tready is low; the walker
// takes the next request meanwhile and holds in its response step until the
// register drains.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [47:0] virt_addr, [99:48] phys_addr, [111:100] flags
   input  logic [ptw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] op
   input  logic [ptw_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [63:0] phys_out
   output logic [ptw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [ptw_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptw_pkg::BASE_W-1:0]         csr_wdata
);
   import ptw_pkg::*;

   logic [BASE_W-1:0]     table_base_ff, table_base_in;
   logic [ROOT_W-1:0]     root_page_ff,  root_page_in;
   logic [FFP_W-1:0]      first_free_ff, first_free_in;
   logic [OP_W-1:0]       op_ff,         op_in;
   logic [VA_W-1:0]       va_ff,         va_in;
   logic [PA_W-1:0]       pa_ff,         pa_in;
   logic [FLAGS_W-1:0]    fl_ff,         fl_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [ENTRY_W-1:0]    rsp_data_ff,   rsp_data_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [ACT_W-1:0]      act;
   dp_flags_type          dp_flags;
   logic [ENTRY_W-1:0]    dp_result;
   logic [STATUS_W-1:0]   dp_status;
   logic                  req_accept;
   logic                  out_busy;
   logic                  rsp_load;

   assign csr_ready  = 1'b1;
   assign req_tready = act == ACT_LOAD;
   assign req_accept = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_load   = (act == ACT_RESP) && !out_busy;

   always_comb begin
      table_base_in = table_base_ff;
      root_page_in  = root_page_ff;
      first_free_in = first_free_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TABLE_BASE: table_base_in = csr_wdata;
            REG_ROOT_PAGE:  root_page_in  = csr_wdata[ROOT_W-1:0];
            REG_FIRST_FREE: first_free_in = csr_wdata[FFP_W-1:0];
            default:        table_base_in = table_base_ff;
         endcase
      end
   end

   always_comb begin
      op_in = op_ff;
      va_in = va_ff;
      pa_in = pa_ff;
      fl_in = fl_ff;
      if (req_accept) begin
         op_in = req_tuser;
         va_in = req_tdata[VA_W-1:0];
         pa_in = req_tdata[VA_W+PA_W-1:VA_W];
         fl_in = req_tdata[VA_W+PA_W+FLAGS_W-1:VA_W+PA_W];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = dp_result;
         rsp_status_in = dp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
         root_page_ff  <= '0;
         first_free_ff <= FIRST_FREE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         table_base_ff <= table_base_in;
         root_page_ff  <= root_page_in;
         first_free_ff <= first_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      fl_ff         <= fl_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   ptw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .flags     (dp_flags),
      .req_valid (req_tvalid),
      .out_busy  (out_busy),
      .act       (act)
   );

   ptw_dp #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .act             (act),
      .op              (op_ff),
      .virt_addr       (va_ff),
      .phys_addr       (pa_ff),
      .flags           (fl_ff),
      .table_base      (table_base_ff),
      .root_page       (root_page_ff),
      .first_free_page (first_free_ff),
      .dp_flags        (dp_flags),
      .result          (dp_result),
      .status          (dp_status)
   );

   // one request in flight
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while a walk was in progress");

   a_full_only_map: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (dp_status == ST_FULL) |-> op_ff == OP_MAP)
      else $error("out-of-pages status on a non-map request");

   a_zero_only_look: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (dp_status == ST_ZERO) |-> (op_ff == OP_UNMAP) || (op_ff == OP_TRANSLATE))
      else $error("zero-entry status on a map request");

   a_result_only_xlat: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (op_ff != OP_TRANSLATE) |-> dp_result == '0)
      else $error("nonzero phys_out on a non-translate request");

endmodule

/* dv/four_level_page_table_walker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_checker
// Watches the csr, req and rsp channels of the page table walker. It keeps a
// shadow copy of the table store, the allocator and the registers, walks each
// accepted request through that shadow, and compares every rsp word in order
// against the walk it predicted.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_checker #(
   parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ptw_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [ptw_pkg::OP_W-1:0]           req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ptw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [ptw_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptw_pkg::BASE_W-1:0]         csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);
   import ptw_pkg::*;

   localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

   typedef struct packed {
      logic [ENTRY_W-1:0]  phys_out;
      logic [STATUS_W-1:0] status;
   } walk_result_type;

   logic [ENTRY_W-1:0] shadow_store [STORE_DEPTH];
   int unsigned        pages_taken;
   logic [BASE_W-1:0]  base_reg;
   logic [ROOT_W-1:0]  root_reg;
   logic [FFP_W-1:0]   free_reg;
   walk_result_type    walk_q [$];
   int                 error_tally = 0;

   function automatic logic [ENTRY_W-1:0] region_base();
      return {{(ENTRY_W-BASE_W){1'b0}}, base_reg[BASE_W-1:OFF_W], {OFF_W{1'b0}}};
   endfunction

   function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va, input int lv);
      return IDX_W'(va >> (39 - 9 * lv));
   endfunction

   // store page an entry points at; 0 when the pointer leaves the region
   function automatic bit page_of_entry(input logic [ENTRY_W-1:0] ent,
                                        output int unsigned pg);
      logic [ENTRY_W-1:0] addr;
      logic [ENTRY_W-1:0] off;
      addr = {ent[ENTRY_W-1:OFF_W], {OFF_W{1'b0}}};
      pg   = 0;
      if (addr < region_base())
         return 1'b0;
      off = (addr - region_base()) >> OFF_W;
      if (off >= TABLE_PAGES)
         return 1'b0;
      pg = 32'(off);
      return 1'b1;
   endfunction

   task automatic walk_tables(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                              input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl,
                              output walk_result_type res);
      int unsigned        pg;
      int unsigned        nx;
      int unsigned        np;
      int unsigned        slot;
      int                 lv;
      int                 k;
      logic [ENTRY_W-1:0] ent;
      res.phys_out = '0;
      res.status   = ST_OK;
      pg           = root_reg;
      if (op == OP_MAP || op == OP_UNMAP || op == OP_TRANSLATE) begin
         if (root_reg >= TABLE_PAGES) begin
            res.status = ST_OUTSIDE;
         end else begin
            for (lv = 0; lv < 3 && res.status == ST_OK; lv++) begin
               slot = pg * ENTRIES_PER_TABLE + level_idx(va, lv);
               ent  = shadow_store[slot];
               nx   = 0;
               if (op == OP_MAP) begin
                  if (!ent[0]) begin
                     np = free_reg + pages_taken;
                     if (np >= TABLE_PAGES) begin
                        res.status = ST_FULL;
                     end else begin
                        pages_taken++;
                        for (k = 0; k < ENTRIES_PER_TABLE; k++)
                           shadow_store[np * ENTRIES_PER_TABLE + k] = '0;
                        ent = (region_base() + (ENTRY_W'(np) << OFF_W)) | ENTRY_W'(DIR_FLAGS);
                        shadow_store[slot] = ent;
                     end
                  end
               end else if (ent[ENTRY_W-1:OFF_W] == '0) begin
                  res.status = ST_ZERO;
               end
               if (res.status == ST_OK && !page_of_entry(ent, nx))
                  res.status = ST_OUTSIDE;
               pg = nx;
            end
            if (res.status == ST_OK) begin
               slot = pg * ENTRIES_PER_TABLE + level_idx(va, 3);
               case (op)
                  OP_MAP: begin
                     shadow_store[slot] = {{(ENTRY_W-PA_W){1'b0}}, pa} | ENTRY_W'(fl);
                  end
                  OP_UNMAP: begin
                     shadow_store[slot] = '0;
                  end
                  default: begin
                     res.phys_out = {shadow_store[slot][ENTRY_W-1:OFF_W], {OFF_W{1'b0}}};
                  end
               endcase
            end
         end
      end
   endtask

   always @(posedge clock) begin
      walk_result_type want;
      int              i;
      if (reset) begin
         for (i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = '0;
         pages_taken = 0;
         base_reg    = '0;
         root_reg    = '0;
         free_reg    = FIRST_FREE_RESET;
         walk_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TABLE_BASE: base_reg = csr_wdata;
               REG_ROOT_PAGE:  root_reg = csr_wdata[ROOT_W-1:0];
               REG_FIRST_FREE: free_reg = csr_wdata[FFP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (walk_q.size() == 0) begin
               $error("rsp word with no request pending: phys_out %h status %0d",
                      rsp_tdata, rsp_tuser);
               error_tally++;
            end else begin
               want = walk_q.pop_front();
               if (rsp_tdata !== want.phys_out) begin
                  $error("phys_out: expected %h, actual %h", want.phys_out, rsp_tdata);
                  error_tally++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            walk_tables(req_tuser, req_tdata[VA_W-1:0], req_tdata[VA_W +: PA_W],
                        req_tdata[VA_W+PA_W +: FLAGS_W], want);
            walk_q.push_back(want);
         end
      end
      mismatches  <= error_tally;
      outstanding <= walk_q.size();
   end

endmodule

/* dv/four_level_page_table_walker_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_tb
// Drives map, unmap, translate and spare-op words into the walker: a directed opening
// on the reset settings, then random phases under several register settings
// (base and page extremes, exhausted allocator, root on a leaf table) with
// bursty idling on both sides. The checker predicts and scores every rsp word.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_tb;
   import ptw_pkg::*;

   localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
   localparam logic [VA_W-1:0]  VA_ONES  = '1;
   localparam logic [PA_W-1:0]  PA_ONES  = '1;
   localparam logic [BASE_W-1:0] BASE_TOP = '1;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [BASE_W-1:0]      csr_wdata;
   int                     mismatches;
   int                     outstanding;
   bit                     calm = 1'b0;
   bit                     gappy = 1'b1;

   four_level_page_table_walker_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   four_level_page_table_walker_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("four_level_page_table_walker_top_tb: done, errors");
      $finish;
   end

   // rsp side: stall bursts mixed with stretches of steady ready
   initial begin
      forever begin
         if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                            input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {fl, pa, va};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && gappy && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every rsp word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // most addresses share a few upper indices so walks go deep and tables get reused
   task automatic pick_item(output logic [OP_W-1:0] op, output logic [VA_W-1:0] va,
                            output logic [PA_W-1:0] pa, output logic [FLAGS_W-1:0] fl);
      int unsigned        r;
      logic [IDX_W-1:0]   l0;
      logic [IDX_W-1:0]   l1;
      logic [IDX_W-1:0]   l2;
      logic [IDX_W-1:0]   l3;
      r = $urandom_range(0, 99);
      if (r < 40)
         op = OP_MAP;
      else if (r < 60)
         op = OP_UNMAP;
      else if (r < 95)
         op = OP_TRANSLATE;
      else
         op = OP_SPARE;
      r  = $urandom_range(0, 2);
      l0 = (r == 0) ? 9'h000 : (r == 1) ? 9'h1FF : 9'h0A5;
      l1 = $urandom_range(0, 1) ? 9'h1FF : 9'h000;
      l2 = $urandom_range(0, 1) ? 9'h1AA : 9'h055;
      l3 = IDX_W'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 9'h1F8 : 9'h000);
      va = {l0, l1, l2, l3, OFF_W'($urandom())};
      if ($urandom_range(0, 99) < ((op == OP_MAP) ? 3 : 15))
         va = VA_W'({$urandom(), $urandom()});
      pa = PA_W'({$urandom(), $urandom()});
      fl = FLAGS_W'($urandom());
   endtask

   task automatic run_phase(input logic [BASE_W-1:0] base, input logic [ROOT_W-1:0] root,
                            input logic [FFP_W-1:0] first_free, input int count,
                            input int calm_tail);
      logic [OP_W-1:0]    op;
      logic [VA_W-1:0]    va;
      logic [PA_W-1:0]    pa;
      logic [FLAGS_W-1:0] fl;
      int                 k;
      drain();
      write_reg(REG_TABLE_BASE, base);
      write_reg(REG_ROOT_PAGE, BASE_W'(root));
      write_reg(REG_FIRST_FREE, BASE_W'(first_free));
      csr_valid <= 1'b0;
      for (k = 0; k < count; k++) begin
         if (k % 50 == 0)
            gappy = ($urandom_range(0, 3) != 0);
         if (k == count / 2)
            drain();
         calm = (k >= count - calm_tail);
         pick_item(op, va, pa, fl);
         send_word(op, va, pa, fl);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_MAP;
      csr_valid  <= 1'b0;
      csr_index  <= REG_TABLE_BASE;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening on reset register values
      send_word(OP_TRANSLATE, '0, '0, '0);
      send_word(OP_UNMAP, '0, '0, '0);
      send_word(OP_SPARE, VA_ONES, PA_ONES, 12'hFFF);
      send_word(OP_MAP, VA_ONES, PA_ONES, 12'hFFF);
      send_word(OP_TRANSLATE, VA_ONES, '0, '0);
      send_word(OP_MAP, '0, '0, '0);
      send_word(OP_TRANSLATE, '0, '0, '0);
      send_word(OP_TRANSLATE, 48'hFFFF_FFFF_E123, '0, '0);
      send_word(OP_UNMAP, VA_ONES, '0, '0);
      send_word(OP_TRANSLATE, VA_ONES, '0, '0);
      send_word(OP_UNMAP, VA_ONES, '0, '0);
      send_word(OP_MAP, 48'h0000_0000_1000, 52'h0_0000_1234_5000, 12'h067);
      send_word(OP_TRANSLATE, 48'h0000_0000_1ABC, '0, '0);
      send_word(OP_MAP, 48'h8000_0000_0000, 52'hA_5A5A_5A5A_5000, 12'h801);
      send_word(OP_TRANSLATE, 48'h8000_0000_0FFF, '0, '0);
      send_word(OP_TRANSLATE, 48'h0000_4000_0000, '0, '0);
      send_word(OP_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_0FFF, 12'h000);
      send_word(OP_TRANSLATE, 48'h0000_0000_2000, '0, '0);
      send_word(OP_SPARE, '0, '0, '0);

      run_phase('0, '0, 7'd1, 500, 0);
      run_phase('0, 6'd63, 7'd64, 150, 0);
      // root on a leaf table: leaf words act as top-level pointers
      run_phase('0, 6'd3, 7'd1, 100, 0);
      run_phase(BASE_TOP, '0, 7'd1, 200, 0);
      run_phase('0, '0, 7'd0, 630, 200);

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("four_level_page_table_walker_top_tb: done, clean");
      end else begin
         $display("four_level_page_table_walker_top_tb: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ptw_pkg.sv
rtl/ptw_seq.sv
rtl/ptw_dp.sv
rtl/four_level_page_table_walker_top.sv
dv/four_level_page_table_walker_checker.sv
dv/four_level_page_table_walker_top_tb.sv
